[rtl/bitmap_block_allocator_next_fit_top_defines.svh]
// Assertion macros for the next-fit bitmap block allocator.
// Included by modules that carry concurrent checks; needs i_clk and i_rst_n in scope.
`ifndef BITMAP_BLOCK_ALLOCATOR_NEXT_FIT_TOP_DEFINES_SVH
`define BITMAP_BLOCK_ALLOCATOR_NEXT_FIT_TOP_DEFINES_SVH

// cond implies expr in the same cycle
`define BBANF_IMPLY(name, cond, expr, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |-> (expr)) \
        else $error(msg);

// cond implies expr in the next cycle
`define BBANF_NEXT(name, cond, expr, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |=> (expr)) \
        else $error(msg);

`endif

[rtl/bbanf_pkg.sv]
// Shared types and codes for the next-fit bitmap block allocator.
// No dependencies.
package bbanf_pkg;

    localparam int BlockW  = 12;
    localparam int StatusW = 2;

    localparam logic FN_ALLOC = 1'b0;
    localparam logic FN_FREE  = 1'b1;

    typedef enum logic [StatusW-1:0] {
        ST_OK,
        ST_FULL,
        ST_BAD_FREE
    } t_status;

endpackage

[rtl/bbanf_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// Read of the address being written returns the new word. No dependencies.
module bbanf_ram #(
    parameter int Width = 32,
    parameter int Depth = 128
) (
    input  logic                                 i_clk,
    input  logic                                 i_we,
    input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] i_waddr,
    input  logic [Width-1:0]                     i_wdata,
    input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] i_raddr,
    output logic [Width-1:0]                     o_rdata
);

    logic [Width-1:0] r_mem [Depth];
    logic [Width-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_we && (i_waddr == i_raddr)) begin
            r_rdata <= i_wdata;
        end else begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/bbanf_ffz.sv]
// Find-first-free unit: lowest clear bit of a map word at or above a start bit.
// Bits past the end of the map in the last word count as used. No dependencies.
module bbanf_ffz #(
    parameter int WordBits = 32,
    parameter int LastBits = 32
) (
    input  logic [WordBits-1:0]         i_word,
    input  logic [$clog2(WordBits)-1:0] i_lo,
    input  logic                        i_last,
    output logic                        o_found,
    output logic [$clog2(WordBits)-1:0] o_idx
);

    localparam int BW = $clog2(WordBits);

    logic [WordBits-1:0] w_free;
    logic [WordBits-1:0] w_low;
    logic [WordBits-1:0] w_lo_mask;
    logic [WordBits-1:0] w_end_mask;

    always_comb begin
        for (int i = 0; i < WordBits; i++) begin
            w_lo_mask[i]  = ((BW+1)'(i) >= {1'b0, i_lo});
            w_end_mask[i] = !i_last || (i < LastBits);
        end
    end

    assign w_free  = ~i_word & w_lo_mask & w_end_mask;
    assign w_low   = w_free & (~w_free + WordBits'(1));
    assign o_found = |w_free;

    always_comb begin
        for (int j = 0; j < BW; j++) begin
            o_idx[j] = 1'b0;
            for (int i = 0; i < WordBits; i++) begin
                if (((i >> j) & 1) == 1) begin
                    o_idx[j] = o_idx[j] | w_low[i];
                end
            end
        end
    end

endmodule

[rtl/bitmap_block_allocator_next_fit_top.sv]
// Next-fit bitmap block allocator: sequencer, cursor and result registers.
// Depends on bbanf_pkg, bbanf_ram, bbanf_ffz and the assertion macro header.
//
// After reset the block clears its bitmap memory one word a cycle with busy
// high. A word is taken when start is high and busy low. A free divides the
// block number by the word size, reads the map word and writes it back with
// the bit cleared only if the block was in use; an allocate marks the cursor
// block used, then scans from the block after it, reading one further map word
// per cycle through the single RAM read port, for at most one lap of the map.
// An allocate on a full map and a free of a block past the map end answer in
// the next cycle without raising busy. Each result is shown on o_granted
// and o_status for one cycle with o_done high and must be taken then: there is
// no back-pressure on the result side.
module bitmap_block_allocator_next_fit_top
    import bbanf_pkg::*;
#(
    parameter int NUM_BLOCKS    = 4096,
    parameter int MAP_WORD_BITS = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic              i_func,
    input  logic [BlockW-1:0] i_block,
    output logic              o_done,
    output logic [BlockW-1:0] o_granted,
    output logic [StatusW-1:0] o_status
);

`include "bitmap_block_allocator_next_fit_top_defines.svh"

    localparam int MapWords = (NUM_BLOCKS + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
    localparam int WA       = (MapWords > 1) ? $clog2(MapWords) : 1;
    localparam int BW       = $clog2(MAP_WORD_BITS);
    localparam int PW       = $clog2(NUM_BLOCKS);
    localparam int CntW     = $clog2(MapWords + 2);
    localparam int LastBits = NUM_BLOCKS - (MapWords - 1) * MAP_WORD_BITS;
    localparam int RecipS   = BlockW + BW;
    localparam int RecipM   = ((1 << RecipS) + MAP_WORD_BITS - 1) / MAP_WORD_BITS;

    typedef enum logic [2:0] {
        S_CLR,
        S_IDLE,
        S_A_UPD,
        S_SCAN,
        S_F_DIV,
        S_F_REM,
        S_F_UPD
    } t_state;

    t_state                r_state;
    logic [WA-1:0]         r_clr;
    logic                  r_full;
    logic [WA-1:0]         r_cur_w;
    logic [BW-1:0]         r_cur_b;
    logic [PW-1:0]         r_cur_base;
    logic [WA-1:0]         r_sc_w;
    logic [BW-1:0]         r_sc_lo;
    logic [PW-1:0]         r_sc_base;
    logic [CntW-1:0]       r_left;
    logic [BlockW-1:0]     r_blk;
    logic [WA-1:0]         r_q;
    logic [BW-1:0]         r_rem;
    logic [PW-1:0]         r_fbase;
    logic                  r_done;
    logic [BlockW-1:0]     r_granted;
    t_status               r_status;

    logic                  ram_we;
    logic [WA-1:0]         ram_waddr;
    logic [MAP_WORD_BITS-1:0] ram_wdata;
    logic [WA-1:0]         ram_raddr;
    logic [MAP_WORD_BITS-1:0] ram_rdata;

    logic                  ffz_found;
    logic [BW-1:0]         ffz_idx;

    logic                  w_blk_ok;
    logic                  w_cur_wrap;
    logic                  w_cur_last_w;
    logic                  w_sc_last_w;
    logic [WA-1:0]         w_start_w;
    logic [BW-1:0]         w_start_lo;
    logic [PW-1:0]         w_start_base;
    logic [WA-1:0]         w_sc_next_w;
    logic [PW-1:0]         w_sc_next_base;
    logic [31:0]           w_div_prod;
    logic [31:0]           w_base_prod;
    logic                  w_free_hit;

    assign busy = (r_state != S_IDLE);

    assign w_blk_ok     = ({20'd0, i_block} < 32'(NUM_BLOCKS));
    assign w_cur_last_w = (r_cur_w == WA'(MapWords - 1));
    assign w_sc_last_w  = (r_sc_w == WA'(MapWords - 1));
    assign w_cur_wrap   = (r_cur_b == BW'(MAP_WORD_BITS - 1)) ||
                          (w_cur_last_w && (r_cur_b == BW'(LastBits - 1)));

    // start of the scan: the block after the one being granted
    always_comb begin
        if (w_cur_wrap) begin
            w_start_w    = w_cur_last_w ? '0 : r_cur_w + WA'(1);
            w_start_base = w_cur_last_w ? '0 : r_cur_base + PW'(MAP_WORD_BITS);
            w_start_lo   = '0;
        end else begin
            w_start_w    = r_cur_w;
            w_start_base = r_cur_base;
            w_start_lo   = r_cur_b + BW'(1);
        end
    end

    assign w_sc_next_w    = w_sc_last_w ? '0 : r_sc_w + WA'(1);
    assign w_sc_next_base = w_sc_last_w ? '0 : r_sc_base + PW'(MAP_WORD_BITS);

    assign w_div_prod  = 32'(r_blk) * 32'(RecipM);
    assign w_base_prod = 32'(r_q) * 32'(MAP_WORD_BITS);
    assign w_free_hit  = ram_rdata[r_rem];

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_cur_w;
        ram_wdata = ram_rdata | (MAP_WORD_BITS'(1) << r_cur_b);
        ram_raddr = r_sc_w;
        case (r_state)
            S_CLR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr;
                ram_wdata = '0;
            end
            S_IDLE: begin
                ram_raddr = r_cur_w;
            end
            S_A_UPD: begin
                ram_we    = 1'b1;
                ram_raddr = w_start_w;
            end
            S_SCAN: begin
                ram_raddr = w_sc_next_w;
            end
            S_F_REM: begin
                ram_raddr = r_q;
            end
            S_F_UPD: begin
                ram_we    = w_free_hit;
                ram_waddr = r_q;
                ram_wdata = ram_rdata & ~(MAP_WORD_BITS'(1) << r_rem);
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    bbanf_ram #(
        .Width (MAP_WORD_BITS),
        .Depth (MapWords)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    bbanf_ffz #(
        .WordBits (MAP_WORD_BITS),
        .LastBits (LastBits)
    ) u_ffz (
        .i_word  (ram_rdata),
        .i_lo    (r_sc_lo),
        .i_last  (w_sc_last_w),
        .o_found (ffz_found),
        .o_idx   (ffz_idx)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLR;
            r_clr      <= '0;
            r_full     <= 1'b0;
            r_cur_w    <= '0;
            r_cur_b    <= '0;
            r_cur_base <= '0;
            r_done     <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                S_CLR: begin
                    r_clr <= r_clr + WA'(1);
                    if (r_clr == WA'(MapWords - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (start) begin
                        r_blk <= i_block;
                        if (i_func == FN_ALLOC) begin
                            if (r_full) begin
                                r_done    <= 1'b1;
                                r_granted <= '0;
                                r_status  <= ST_FULL;
                            end else begin
                                r_state <= S_A_UPD;
                            end
                        end else if (!w_blk_ok) begin
                            r_done    <= 1'b1;
                            r_granted <= '0;
                            r_status  <= ST_BAD_FREE;
                        end else begin
                            r_state <= S_F_DIV;
                        end
                    end
                end
                S_A_UPD: begin
                    r_granted <= BlockW'(r_cur_base + PW'(r_cur_b));
                    r_sc_w    <= w_start_w;
                    r_sc_lo   <= w_start_lo;
                    r_sc_base <= w_start_base;
                    r_left    <= CntW'(MapWords + 1);
                    r_state   <= S_SCAN;
                end
                S_SCAN: begin
                    if (ffz_found) begin
                        r_cur_w    <= r_sc_w;
                        r_cur_b    <= ffz_idx;
                        r_cur_base <= r_sc_base;
                        r_done     <= 1'b1;
                        r_status   <= ST_OK;
                        r_state    <= S_IDLE;
                    end else if (r_left == CntW'(1)) begin
                        r_full   <= 1'b1;
                        r_done   <= 1'b1;
                        r_status <= ST_OK;
                        r_state  <= S_IDLE;
                    end else begin
                        r_left    <= r_left - CntW'(1);
                        r_sc_w    <= w_sc_next_w;
                        r_sc_base <= w_sc_next_base;
                        r_sc_lo   <= '0;
                    end
                end
                S_F_DIV: begin
                    r_q     <= WA'(w_div_prod >> RecipS);
                    r_state <= S_F_REM;
                end
                S_F_REM: begin
                    r_rem   <= BW'(32'(r_blk) - w_base_prod);
                    r_fbase <= PW'(w_base_prod);
                    r_state <= S_F_UPD;
                end
                S_F_UPD: begin
                    r_done    <= 1'b1;
                    r_granted <= '0;
                    r_state   <= S_IDLE;
                    if (w_free_hit) begin
                        r_status <= ST_OK;
                        if (r_full) begin
                            r_full     <= 1'b0;
                            r_cur_w    <= r_q;
                            r_cur_b    <= r_rem;
                            r_cur_base <= r_fbase;
                        end
                    end else begin
                        r_status <= ST_BAD_FREE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_done    = r_done;
    assign o_granted = r_granted;
    assign o_status  = r_status;

    `BBANF_IMPLY(a_full_result_held, o_done && (o_status == ST_FULL), r_full,
                 "map-full result while map not marked full")
    `BBANF_IMPLY(a_fail_grants_zero, o_done && (o_status != ST_OK), o_granted == '0,
                 "failed word carries a nonzero block")
    `BBANF_IMPLY(a_scan_bounded, r_state == S_SCAN, r_left != '0,
                 "scan ran past one full lap of the map")
    `BBANF_NEXT(a_free_goes_busy, start && !busy && (i_func == FN_FREE) && w_blk_ok, busy,
                "in-range free did not start the free sequence")
    `BBANF_IMPLY(a_cursor_in_map, !r_full, r_cur_w <= WA'(MapWords - 1),
                 "cursor word outside the map")

endmodule

[tb/tb_top.sv]
// Self-checking testbench for the next-fit bitmap block allocator.
// Drives alloc/free words, predicts every result in-bench, checks each o_done word.
// Depends on bbanf_pkg and bitmap_block_allocator_next_fit_top.
module tb_top;
    import bbanf_pkg::*;

    localparam int NumBlocks   = 4096;
    localparam int MapWordBits = 32;
    localparam int DrainCycles = NumBlocks / MapWordBits + 16;

    typedef struct packed {
        logic [BlockW-1:0] granted;
        t_status           status;
    } t_grant;

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    logic               i_func;
    logic [BlockW-1:0]  i_block;
    logic               o_done;
    logic [BlockW-1:0]  o_granted;
    logic [StatusW-1:0] o_status;

    bit                used_blocks [NumBlocks];
    int                blocks_in_use;
    logic [BlockW-1:0] next_fit;
    bit                map_is_full;
    t_grant            pending_grants[$];
    int                mismatch_count;
    bit                allow_idle;

    bitmap_block_allocator_next_fit_top #(
        .NUM_BLOCKS   (NumBlocks),
        .MAP_WORD_BITS(MapWordBits)
    ) dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_func   (i_func),
        .i_block  (i_block),
        .o_done   (o_done),
        .o_granted(o_granted),
        .o_status (o_status)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #50_000_000;
        $display("bitmap_block_allocator_next_fit_top regression: fail");
        $finish;
    end

    function automatic t_grant allocate_or_free(logic fn, logic [BlockW-1:0] blk);
        t_grant r;
        int     g;
        int     pos;
        bit     found;
        r.granted = '0;
        r.status  = ST_OK;
        found     = 1'b0;
        if (fn == FN_ALLOC) begin
            if (map_is_full) begin
                r.status = ST_FULL;
            end else begin
                g = next_fit;
                r.granted = next_fit;
                used_blocks[g] = 1'b1;
                blocks_in_use++;
                for (int k = 1; k <= NumBlocks && !found; k++) begin
                    pos = (g + k) % NumBlocks;
                    if (!used_blocks[pos]) begin
                        found = 1'b1;
                        next_fit = BlockW'(pos);
                    end
                end
                if (!found)
                    map_is_full = 1'b1;
            end
        end else if (blk >= NumBlocks || !used_blocks[blk]) begin
            r.status = ST_BAD_FREE;
        end else begin
            used_blocks[blk] = 1'b0;
            blocks_in_use--;
            if (map_is_full) begin
                next_fit = blk;
                map_is_full = 1'b0;
            end
        end
        return r;
    endfunction

    function automatic logic [BlockW-1:0] pick_used_block();
        logic [BlockW-1:0] b;
        b = BlockW'($urandom_range(0, NumBlocks - 1));
        if (blocks_in_use == 0)
            return b;
        while (!used_blocks[b])
            b = BlockW'($urandom_range(0, NumBlocks - 1));
        return b;
    endfunction

    task automatic report_mismatch(string what, int want, int got);
        $display("MISMATCH %s: expected %0d got %0d at %0t", what, want, got, $time);
        mismatch_count++;
    endtask

    task automatic maybe_pause();
        if (allow_idle && $urandom_range(0, 99) < 34) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
    endtask

    // called at a rising edge; returns at the edge that takes the word
    task automatic send_word(logic fn, logic [BlockW-1:0] blk);
        start   <= 1'b1;
        i_func  <= fn;
        i_block <= blk;
        do @(posedge i_clk); while (busy !== 1'b0);
        pending_grants.push_back(allocate_or_free(fn, blk));
        maybe_pause();
    endtask

    task automatic wait_all_answered();
        start <= 1'b0;
        while (pending_grants.size() != 0)
            @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        t_grant want;
        if (i_rst_n && o_done === 1'b1) begin
            if (pending_grants.size() == 0) begin
                report_mismatch("unexpected result word", -1, o_granted);
            end else begin
                want = pending_grants.pop_front();
                if (o_granted !== want.granted)
                    report_mismatch("granted", want.granted, o_granted);
                if (o_status !== want.status)
                    report_mismatch("status", want.status, o_status);
            end
        end
    end

    // fresh map, cursor steps, double free, free of never-used block
    task automatic test_directed();
        send_word(FN_ALLOC, '0);
        send_word(FN_ALLOC, '1);
        send_word(FN_ALLOC, 12'hAAA);
        send_word(FN_FREE, 12'd1);
        send_word(FN_ALLOC, 12'h555);
        send_word(FN_ALLOC, '0);
        send_word(FN_FREE, 12'd1);
        send_word(FN_FREE, BlockW'(NumBlocks - 1));
        send_word(FN_FREE, '0);
        send_word(FN_FREE, '0);
        send_word(FN_FREE, 12'h555);
        send_word(FN_ALLOC, '1);
    endtask

    // allocate a long run, then frees and allocs around it
    task automatic test_fill();
        logic [BlockW-1:0] hole;
        for (int i = 0; i < 1000 && !map_is_full; i++)
            send_word(FN_ALLOC, BlockW'($urandom_range(0, NumBlocks - 1)));
        send_word(FN_ALLOC, '0);
        send_word(FN_ALLOC, '1);
        hole = pick_used_block();
        send_word(FN_FREE, hole);
        send_word(FN_ALLOC, '0);
        send_word(FN_FREE, '0);
        send_word(FN_FREE, BlockW'(NumBlocks - 1));
        send_word(FN_ALLOC, '0);
        send_word(FN_ALLOC, '0);
        send_word(FN_ALLOC, '0);
        wait_all_answered();
    endtask

    // mixed traffic, mostly valid frees
    task automatic test_random();
        int                p_alloc;
        logic              fn;
        logic [BlockW-1:0] blk;
        p_alloc = 50;
        for (int i = 0; i < 540; i++) begin
            if (i % 100 == 0)
                p_alloc = 30 + 20 * $urandom_range(0, 2);
            allow_idle = !(i >= 200 && i < 300);
            fn = ($urandom_range(0, 99) < p_alloc) ? FN_ALLOC : FN_FREE;
            if (map_is_full && $urandom_range(0, 3) != 0)
                fn = FN_FREE;
            blk = BlockW'($urandom_range(0, NumBlocks - 1));
            if (fn == FN_FREE && $urandom_range(0, 4) != 0)
                blk = pick_used_block();
            send_word(fn, blk);
        end
        allow_idle = 1'b1;
    endtask

    initial begin
        i_rst_n        <= 1'b0;
        start          <= 1'b0;
        i_func         <= FN_ALLOC;
        i_block        <= '0;
        blocks_in_use  = 0;
        next_fit       = '0;
        map_is_full    = 1'b0;
        mismatch_count = 0;
        allow_idle     = 1'b1;
        foreach (used_blocks[k])
            used_blocks[k] = 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_fill();
        test_random();

        wait_all_answered();
        repeat (DrainCycles) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("bitmap_block_allocator_next_fit_top regression: pass");
        else
            $display("bitmap_block_allocator_next_fit_top regression: fail");
        $finish;
    end

endmodule
